// File: hdl/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types and constants for the xorshift random generator: operation
// codes, controller states, datapath step codes and hash constants.
// ----------------------------------------------------------------------------
package xrg_pkg;

  // operation codes on the op field (code 3 only returns a result)
  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_SEED = 2'd1,
    OP_LOAD = 2'd2
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_RANGE_MUL,
    ST_MIX_A,
    ST_MIX_B,
    ST_HASH_SET,
    ST_LOAD_SET,
    ST_FINISH
  } state_t;

  // datapath step selected by the controller
  typedef enum logic [2:0] {
    STEP_HOLD,
    STEP_ADVANCE,
    STEP_RANGE_MUL,
    STEP_MIX_A,
    STEP_MIX_B,
    STEP_HASH_SET,
    STEP_LOAD_SET
  } step_t;

  // command bundle from controller to datapath
  typedef struct packed {
    logic  capture;      // take the input transfer into the operand registers
    step_t step;         // datapath step for this cycle
    logic  result_load;  // load the output register
  } dp_cmd_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 64;

  localparam logic [WORD_W-1:0] GOLDEN_ADD = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 32'hC2B2_AE35;

  localparam int unsigned XS_SHIFT_A = 13;
  localparam int unsigned XS_SHIFT_B = 17;
  localparam int unsigned XS_SHIFT_C = 5;
  localparam int unsigned MIX_SHIFT_A = 16;
  localparam int unsigned MIX_SHIFT_B = 13;

  // one xorshift32 update
  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << XS_SHIFT_A);
    y = y ^ (y >> XS_SHIFT_B);
    y = y ^ (y << XS_SHIFT_C);
    return y;
  endfunction

  // state value with zero replaced by one
  function automatic logic [WORD_W-1:0] nonzero(input logic [WORD_W-1:0] x);
    return (x == '0) ? WORD_W'(1) : x;
  endfunction

endpackage

// File: hdl/xrg_ctrl.sv
// ----------------------------------------------------------------------------
// xrg_ctrl
// Controller for the xorshift random generator: sequences one operation at a
// time through the datapath and owns the handshake on both channels.
// ----------------------------------------------------------------------------
module xrg_ctrl
  import xrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    out_valid_next  = out_valid && !out_ready;
    in_ready        = 1'b0;
    cmd.capture     = 1'b0;
    cmd.step        = STEP_HOLD;
    cmd.result_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (op)
            OP_DRAW: state_next = ST_ADVANCE;
            OP_SEED: state_next = ST_MIX_A;
            OP_LOAD: state_next = ST_LOAD_SET;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_ADVANCE: begin
        cmd.step   = STEP_ADVANCE;
        state_next = ST_RANGE_MUL;
      end
      ST_RANGE_MUL: begin
        cmd.step   = STEP_RANGE_MUL;
        state_next = ST_FINISH;
      end
      ST_MIX_A: begin
        cmd.step   = STEP_MIX_A;
        state_next = ST_MIX_B;
      end
      ST_MIX_B: begin
        cmd.step   = STEP_MIX_B;
        state_next = ST_HASH_SET;
      end
      ST_HASH_SET: begin
        cmd.step   = STEP_HASH_SET;
        state_next = ST_FINISH;
      end
      ST_LOAD_SET: begin
        cmd.step   = STEP_LOAD_SET;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/xrg_datapath.sv
// ----------------------------------------------------------------------------
// xrg_datapath
// Datapath for the xorshift random generator: generator state, draw counter,
// operand registers, one shared 32x32 multiplier and the output register.
// ----------------------------------------------------------------------------
module xrg_datapath
  import xrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  logic [1:0]                op,
  input  logic [WORD_W-1:0]         load_value,
  input  logic signed [WORD_W-1:0]  range_low,
  input  logic signed [WORD_W-1:0]  range_high,
  output logic [WORD_W-1:0]         raw_word,
  output logic signed [WORD_W-1:0]  ranged_value,
  output logic [WORD_W-1:0]         state_now,
  output logic [COUNT_W-1:0]        draw_total,
  output logic                      range_error
);

  logic [WORD_W-1:0]          gen_state;
  logic [COUNT_W-1:0]         draw_count;
  logic [1:0]                 op_q;
  logic [WORD_W-1:0]          load_q;
  logic signed [WORD_W-1:0]   low_q;
  logic signed [WORD_W-1:0]   high_q;
  logic [WORD_W-1:0]          work;
  logic [WORD_W:0]            span;
  logic                       err;
  logic [2*WORD_W-1:0]        prod;

  logic [WORD_W-1:0]          mul_a;
  logic [WORD_W-1:0]          mul_b;
  logic [WORD_W-1:0]          prod_lo;
  logic [WORD_W-1:0]          adv_word;
  logic [WORD_W:0]            span_calc;
  logic [WORD_W-1:0]          offs;
  logic [WORD_W-1:0]          ranged_calc;
  logic                       is_draw;

  assign prod_lo  = prod[WORD_W-1:0];
  assign adv_word = xs_advance(gen_state);
  assign is_draw  = (op_q == OP_DRAW);

  // span of the range, up to 2^32, from sign-extended bounds
  assign span_calc = {high_q[WORD_W-1], high_q} - {low_q[WORD_W-1], low_q}
                     + (WORD_W+1)'(1);

  // shared multiplier operand select
  always_comb begin
    case (cmd.step)
      STEP_MIX_A: begin
        mul_a = work ^ (work >> MIX_SHIFT_A);
        mul_b = MIX_MUL_A;
      end
      STEP_MIX_B: begin
        mul_a = prod_lo ^ (prod_lo >> MIX_SHIFT_B);
        mul_b = MIX_MUL_B;
      end
      default: begin
        mul_a = span[WORD_W-1:0];
        mul_b = work;
      end
    endcase
  end

  // a full span of 2^32 maps the word onto itself
  assign offs        = span[WORD_W] ? work : prod[2*WORD_W-1:WORD_W];
  assign ranged_calc = err ? low_q : low_q + offs;

  // generator state and draw counter
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state  <= WORD_W'(1);
      draw_count <= '0;
    end else begin
      case (cmd.step)
        STEP_ADVANCE: begin
          gen_state  <= adv_word;
          draw_count <= draw_count + COUNT_W'(1);
        end
        STEP_HASH_SET: gen_state <= nonzero(prod_lo ^ (prod_lo >> MIX_SHIFT_A));
        STEP_LOAD_SET: gen_state <= nonzero(load_q);
        default: ;
      endcase
    end
  end

  // operand capture, working registers and multiplier
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      load_q <= load_value;
      low_q  <= range_low;
      high_q <= range_high;
      work   <= load_value + GOLDEN_ADD;
    end
    case (cmd.step) inside
      STEP_ADVANCE: begin
        work <= adv_word;
        span <= span_calc;
        err  <= (high_q < low_q);
      end
      STEP_RANGE_MUL, STEP_MIX_A, STEP_MIX_B: prod <= mul_a * mul_b;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      raw_word     <= is_draw ? work : '0;
      ranged_value <= is_draw ? ranged_calc : '0;
      range_error  <= is_draw && err;
      state_now    <= gen_state;
      draw_total   <= draw_count;
    end
  end

endmodule

// File: hdl/xorshift_random_generator.sv
// ----------------------------------------------------------------------------
// xorshift_random_generator
// 32-bit xorshift generator with seed hashing, direct state load, a 64-bit
// draw counter and an integer draw mapped into a signed range.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. The seed and the ranged draw are paced
// by the single shared 32x32 multiplier, used once per draw and twice per seed.
// The next input is taken once the current result sits in the output
// register, so a result waiting for out_ready does not block a new transfer.
module xorshift_random_generator
  import xrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [WORD_W-1:0]         load_value,
  input  logic signed [WORD_W-1:0]  range_low,
  input  logic signed [WORD_W-1:0]  range_high,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WORD_W-1:0]         raw_word,
  output logic signed [WORD_W-1:0]  ranged_value,
  output logic [WORD_W-1:0]         state_now,
  output logic [COUNT_W-1:0]        draw_total,
  output logic                      range_error
);

  dp_cmd_t cmd;

  // sequencer
  xrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // state, arithmetic and output register
  xrg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op           (op),
    .load_value   (load_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .raw_word     (raw_word),
    .ranged_value (ranged_value),
    .state_now    (state_now),
    .draw_total   (draw_total),
    .range_error  (range_error)
  );

endmodule

// File: hdl/xrg_checker.sv
// ----------------------------------------------------------------------------
// xrg_checker
// Port-level checks for the xorshift random generator, bound to the top level.
// ----------------------------------------------------------------------------
module xrg_checker
  import xrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [WORD_W-1:0]         raw_word,
  input  logic [WORD_W-1:0]         state_now,
  input  logic                      range_error
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(state_now) && $stable(raw_word))
    else $error("result changed while stalled");

  // one operation at a time: no transfer in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in flight");

  // the reported state is never zero
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state_now != '0)
    else $error("zero generator state reported");

  // a range error only comes with a draw, whose word is never zero
  a_error_on_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> raw_word != '0)
    else $error("range error on a non-draw result");

endmodule

bind xorshift_random_generator xrg_checker u_xrg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .raw_word    (raw_word),
  .state_now   (state_now),
  .range_error (range_error)
);

// File: dv/tb_xorshift_random_generator.sv
// ----------------------------------------------------------------------------
// tb_xorshift_random_generator
// Self-checking bench for the xorshift random generator. A shadow copy of the
// generator state and draw counter predicts every result from the accepted
// requests, and each result transfer is compared field by field in order.
// Directed corner cases come first, then random traffic in three idle mixes,
// with long output stalls and a full drain along the way.
// ----------------------------------------------------------------------------
module tb_xorshift_random_generator;
  import xrg_pkg::*;

  localparam logic [1:0]               OP_UNUSED    = 2'd3;
  localparam logic signed [WORD_W-1:0] INT_MIN      = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] INT_MAX      = 32'sh7FFF_FFFF;
  // seed whose golden-ratio add wraps to zero, so the hash gives zero
  localparam logic [WORD_W-1:0]        SEED_TO_ZERO = 32'h61C8_8647;
  localparam int                       HOLD_CYCLES  = 400;
  localparam int                       TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [WORD_W-1:0]        raw;
    logic signed [WORD_W-1:0] ranged;
    logic [WORD_W-1:0]        state;
    logic [COUNT_W-1:0]       total;
    logic                     err;
  } draw_result_t;

  // shadow generator: predicts each result and holds the ones still owed
  class xorshift_shadow;
    logic [WORD_W-1:0]  gen_word;
    logic [COUNT_W-1:0] draws;
    draw_result_t       owed[$];
    int                 fail_cnt;

    function new();
      gen_word = 32'd1;
      draws    = '0;
      fail_cnt = 0;
    endfunction

    function logic [WORD_W-1:0] xorshift_next(logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
    endfunction

    // golden-ratio add then murmur3 finalizer
    function logic [WORD_W-1:0] mix_seed(logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] z;
      z = seed + GOLDEN_ADD;
      z = (z ^ (z >> 16)) * MIX_MUL_A;
      z = (z ^ (z >> 13)) * MIX_MUL_B;
      z = z ^ (z >> 16);
      return z;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // accepted input transfer: update shadow state, queue the result
    function void take_request(logic [1:0] opc, logic [WORD_W-1:0] load,
                               logic signed [WORD_W-1:0] lo,
                               logic signed [WORD_W-1:0] hi);
      draw_result_t      r;
      logic [63:0]       span;
      logic [63:0]       prod;
      logic [WORD_W-1:0] h;
      r = '0;
      case (opc)
        OP_DRAW: begin
          gen_word = xorshift_next(gen_word);
          draws    = draws + 1;
          r.raw    = gen_word;
          if (hi < lo) begin
            r.err    = 1'b1;
            r.ranged = lo;
          end else begin
            // span reaches 2^32 on the full range, product still fits 64 bits
            span     = 64'(longint'(hi) - longint'(lo) + 1);
            prod     = span * {32'd0, gen_word};
            r.ranged = lo + prod[63:32];
          end
        end
        OP_SEED: begin
          h        = mix_seed(load);
          gen_word = (h == '0) ? 32'd1 : h;
        end
        OP_LOAD: begin
          gen_word = (load == '0) ? 32'd1 : load;
        end
        default: begin
        end
      endcase
      r.state = gen_word;
      r.total = draws;
      owed.push_back(r);
    endfunction

    // result transfer: compare against the oldest owed result
    function void match_result(logic [WORD_W-1:0] raw, logic signed [WORD_W-1:0] ranged,
                               logic [WORD_W-1:0] state, logic [COUNT_W-1:0] total,
                               logic err);
      draw_result_t e;
      if (owed.size() == 0) begin
        $error("result transfer with no request outstanding: raw_word %h", raw);
        fail_cnt++;
        return;
      end
      e = owed.pop_front();
      if (raw !== e.raw) begin
        $error("raw_word: expected %h, actual %h", e.raw, raw);
        fail_cnt++;
      end
      if (ranged !== e.ranged) begin
        $error("ranged_value: expected %0d, actual %0d", e.ranged, ranged);
        fail_cnt++;
      end
      if (state !== e.state) begin
        $error("state_now: expected %h, actual %h", e.state, state);
        fail_cnt++;
      end
      if (total !== e.total) begin
        $error("draw_total: expected %0d, actual %0d", e.total, total);
        fail_cnt++;
      end
      if (err !== e.err) begin
        $error("range_error: expected %b, actual %b", e.err, err);
        fail_cnt++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [1:0]                op           = '0;
  logic [WORD_W-1:0]         load_value   = '0;
  logic signed [WORD_W-1:0]  range_low    = '0;
  logic signed [WORD_W-1:0]  range_high   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [WORD_W-1:0]         raw_word;
  logic signed [WORD_W-1:0]  ranged_value;
  logic [WORD_W-1:0]         state_now;
  logic [COUNT_W-1:0]        draw_total;
  logic                      range_error;

  xorshift_shadow shadow = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  xorshift_random_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .load_value   (load_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_word     (raw_word),
    .ranged_value (ranged_value),
    .state_now    (state_now),
    .draw_total   (draw_total),
    .range_error  (range_error)
  );

  always #5 clk = ~clk;

  // hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.match_result(raw_word, ranged_value, state_now, draw_total, range_error);
  end

  // offer one request and wait for its transfer
  task automatic offer_op(logic [1:0] opc, logic [WORD_W-1:0] load,
                          logic signed [WORD_W-1:0] lo, logic signed [WORD_W-1:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= opc;
    load_value <= load;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (!in_ready);
    shadow.take_request(opc, load, lo, hi);
  endtask

  // stop offering until every owed result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic offer_random();
    int                       pick;
    logic [1:0]               opc;
    logic [WORD_W-1:0]        load;
    logic signed [WORD_W-1:0] lo;
    logic signed [WORD_W-1:0] hi;
    pick = $urandom_range(0, 99);
    if (pick < 70)      opc = OP_DRAW;
    else if (pick < 80) opc = OP_SEED;
    else if (pick < 92) opc = OP_LOAD;
    else                opc = OP_UNUSED;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: load = $urandom;
      5:             load = $urandom_range(0, 3);
      6:             load = SEED_TO_ZERO;
      default:       load = ~32'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        lo = $urandom;
        hi = $urandom;
      end
      4, 5, 6: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 1000);
      end
      7: begin
        lo = INT_MIN;
        hi = INT_MAX;
      end
      8: begin
        lo = $urandom;
        hi = lo - $urandom_range(1, 50);
      end
      default: begin
        lo = 32'sd0 - $urandom_range(0, 10);
        hi = $urandom_range(0, 10);
      end
    endcase
    offer_op(opc, load, lo, hi);
  endtask

  // random traffic with an optional long output hold and a full drain
  task automatic random_phase(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_asks++;
      if (i == pause_at) drain();
      offer_random();
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender idles less than receiver
    send_idle_pct = 36;
    recv_idle_pct = 68;

    // directed corner cases
    offer_op(OP_DRAW,   32'd0,         32'sd0,   32'sd0);
    offer_op(OP_DRAW,   32'd0,         INT_MIN,  INT_MAX);
    offer_op(OP_DRAW,   32'd0,         INT_MAX,  INT_MIN);
    offer_op(OP_DRAW,   32'hFFFF_FFFF, INT_MIN,  INT_MIN);
    offer_op(OP_DRAW,   32'd0,         INT_MAX,  INT_MAX);
    offer_op(OP_DRAW,   32'd0,         -32'sd5,  32'sd5);
    offer_op(OP_DRAW,   32'd0,         32'sd1,   32'sd0);
    offer_op(OP_SEED,   32'd0,         INT_MIN,  INT_MAX);
    offer_op(OP_DRAW,   32'd0,         INT_MIN,  -32'sd1);
    offer_op(OP_SEED,   32'hFFFF_FFFF, 32'sd0,   32'sd0);
    offer_op(OP_SEED,   SEED_TO_ZERO,  32'sd0,   32'sd0);
    offer_op(OP_DRAW,   32'd0,         32'sd0,   INT_MAX);
    offer_op(OP_LOAD,   32'd0,         32'sd0,   32'sd0);
    offer_op(OP_DRAW,   32'd0,         INT_MIN,  INT_MAX);
    offer_op(OP_LOAD,   32'hFFFF_FFFF, INT_MAX,  INT_MIN);
    offer_op(OP_DRAW,   32'd0,         INT_MIN,  INT_MAX);
    offer_op(OP_LOAD,   32'h8000_0000, 32'sd0,   32'sd0);
    offer_op(OP_DRAW,   32'd0,         -32'sd1,  32'sd0);
    offer_op(OP_UNUSED, 32'hFFFF_FFFF, INT_MIN,  INT_MAX);
    offer_op(OP_UNUSED, 32'd0,         INT_MAX,  INT_MIN);
    offer_op(OP_DRAW,   32'h1234_5678, 32'sd100, 32'sd200);
    drain();

    random_phase(600, 100, 300);

    // receiver idles less than sender
    send_idle_pct = 68;
    recv_idle_pct = 36;
    random_phase(600, -1, -1);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600, 250, -1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.pending() != 0) begin
      $error("%0d results never arrived", shadow.pending());
      shadow.fail_cnt++;
    end
    if (shadow.fail_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: xorshift_random_generator.f
hdl/xrg_pkg.sv
hdl/xrg_ctrl.sv
hdl/xrg_datapath.sv
hdl/xorshift_random_generator.sv
hdl/xrg_checker.sv
dv/tb_xorshift_random_generator.sv
